/* src/apm_pkg.sv */
// Shared constants and the inter-cell link type for the approximate pattern matcher.
package apm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int REG_CHARS = 16;
   localparam int CHAR_W = 8;
   localparam int DIST_W = 5;
   localparam int POS_W = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ERRORS = 2'd3;

   typedef struct packed {
      logic              valid;
      logic              restart;
      logic [CHAR_W-1:0] ch;
      logic [DIST_W-1:0] above;
      logic [DIST_W-1:0] diag;
      logic [DIST_W-1:0] bottom;
   } link_type;

endpackage

/* src/apm_cell.sv */
// One systolic cell: holds one row of the distance column and passes the text byte on.
module apm_cell #(
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [apm_pkg::CHAR_W-1:0] pattern_char,
   input  logic                       select,
   input  apm_pkg::link_type          up_link,
   output apm_pkg::link_type          down_link
);

   localparam logic [apm_pkg::DIST_W-1:0] RESET_VALUE = apm_pkg::DIST_W'(INDEX + 1);
   localparam logic [apm_pkg::DIST_W:0] SAT_VALUE = {1'b0, {apm_pkg::DIST_W{1'b1}}};

   logic [apm_pkg::DIST_W-1:0] col_ff, col_in;
   apm_pkg::link_type          link_ff, link_in;
   logic [apm_pkg::DIST_W-1:0] old_value;
   logic [apm_pkg::DIST_W:0]   cost, del_sum, ins_sum, sub_sum, min_a, min_b;
   logic [apm_pkg::DIST_W-1:0] best;

   always_comb begin
      old_value = up_link.restart ? RESET_VALUE : col_ff;
      cost = {{apm_pkg::DIST_W{1'b0}}, (pattern_char != up_link.ch)};
      del_sum = {1'b0, old_value} + 1'b1;
      ins_sum = {1'b0, up_link.above} + 1'b1;
      sub_sum = {1'b0, up_link.diag} + cost;
      min_a = (del_sum < ins_sum) ? del_sum : ins_sum;
      min_b = (min_a < sub_sum) ? min_a : sub_sum;
      best = (min_b > SAT_VALUE) ? SAT_VALUE[apm_pkg::DIST_W-1:0]
                                 : min_b[apm_pkg::DIST_W-1:0];
   end

   always_comb begin
      col_in = col_ff;
      link_in = link_ff;
      if (advance) begin
         link_in.valid = up_link.valid;
         if (up_link.valid) begin
            col_in = best;
            link_in.restart = up_link.restart;
            link_in.ch = up_link.ch;
            link_in.above = best;
            link_in.diag = old_value;
            link_in.bottom = select ? best : up_link.bottom;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= RESET_VALUE;
         link_ff <= '0;
      end else begin
         col_ff <= col_in;
         link_ff <= link_in;
      end
   end

   assign down_link = link_ff;

endmodule

/* src/approximate_pattern_match.sv */
// Top level: CSR bank, skewed row of edit-distance cells and result position counter.
//
//   channel | direction | transfer when          | payload
//   req     | in        | req_valid & req_ready  | req_text_char, req_restart
//   rsp     | out       | rsp_valid & rsp_ready  | rsp_distance, rsp_is_match, rsp_text_position
//   csr     | in        | csr_valid & csr_ready  | csr_index, csr_data
//
// One byte per cycle unless stalled; the row is ROWS cells long (ROWS = min(PATTERN_MAX, 16)).
// The last cell's stage is the output register; the whole row freezes while it holds an
// untaken result, and req_ready follows.
// Reset is synchronous: column rows return to i+1, position to zero, pattern to defaults.
// CSR writes are always taken.
module approximate_pattern_match #(
   parameter int PATTERN_MAX = apm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [apm_pkg::CHAR_W-1:0]      req_text_char,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [apm_pkg::DIST_W-1:0]      rsp_distance,
   output logic                            rsp_is_match,
   output logic [apm_pkg::POS_W-1:0]       rsp_text_position,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [apm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [apm_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int ROWS = (PATTERN_MAX < apm_pkg::REG_CHARS) ? PATTERN_MAX : apm_pkg::REG_CHARS;
   localparam logic [apm_pkg::POS_W-1:0] POS_MAX = {apm_pkg::POS_W{1'b1}};

   logic [apm_pkg::CSR_DATA_W-1:0]   pat_lo_ff, pat_hi_ff;
   logic [apm_pkg::DIST_W-1:0]       len_ff, max_err_ff;
   logic [2*apm_pkg::CSR_DATA_W-1:0] pattern;
   logic [apm_pkg::DIST_W-1:0]       m_eff;
   logic [apm_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic                             advance;
   apm_pkg::link_type                links [0:ROWS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         len_ff <= apm_pkg::DIST_W'(1);
         max_err_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            apm_pkg::CSR_PATTERN_LOW: pat_lo_ff <= csr_data;
            apm_pkg::CSR_PATTERN_HIGH: pat_hi_ff <= csr_data;
            apm_pkg::CSR_PATTERN_LENGTH: len_ff <= csr_data[apm_pkg::DIST_W-1:0];
            apm_pkg::CSR_MAX_ERRORS: max_err_ff <= csr_data[apm_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern = {pat_hi_ff, pat_lo_ff};

   always_comb begin
      if (len_ff == '0) begin
         m_eff = apm_pkg::DIST_W'(1);
      end else if (len_ff > apm_pkg::DIST_W'(ROWS)) begin
         m_eff = apm_pkg::DIST_W'(ROWS);
      end else begin
         m_eff = len_ff;
      end
   end

   assign advance = !links[ROWS].valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      links[0].valid = req_valid;
      links[0].restart = req_restart;
      links[0].ch = req_text_char;
      links[0].above = '0;
      links[0].diag = '0;
      links[0].bottom = '0;
   end

   for (genvar i = 0; i < ROWS; i++) begin : g_cell
      apm_cell #(
         .INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .pattern_char(pattern[apm_pkg::CHAR_W*i +: apm_pkg::CHAR_W]),
         .select(m_eff == apm_pkg::DIST_W'(i + 1)),
         .up_link(links[i]),
         .down_link(links[i+1])
      );
   end

   assign rsp_valid = links[ROWS].valid;
   assign rsp_distance = links[ROWS].bottom;
   assign rsp_is_match = (links[ROWS].bottom <= max_err_ff);
   assign rsp_text_position = links[ROWS].restart ? '0 : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && rsp_ready) begin
         pos_in = (rsp_text_position == POS_MAX) ? POS_MAX : rsp_text_position + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

`ifndef SYNTHESIS
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance <= m_eff)
      else $error("distance exceeds pattern length");

   a_req_enters_row: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> links[1].valid)
      else $error("accepted byte missing from first cell");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=>
         (pos_ff == (($past(rsp_text_position) == POS_MAX) ? POS_MAX
                                                          : $past(rsp_text_position) + 1'b1)))
      else $error("position counter did not step");
`endif

endmodule
